[hw/rtl/wia_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// wia_pkg
// Shared types and operation codes of the integer helper unit.
// ---------------------------------------------------------------------------
package wia_pkg;

   localparam int unsigned DataWidth  = 64;
   localparam int unsigned ModeWidth  = 5;
   localparam int unsigned FaultWidth = 2;
   localparam int unsigned QueueDepth = 2;

   localparam logic [4:0] OP_EQZ    = 5'd0;
   localparam logic [4:0] OP_CLZ64  = 5'd1;
   localparam logic [4:0] OP_CTZ64  = 5'd2;
   localparam logic [4:0] OP_POP64  = 5'd3;
   localparam logic [4:0] OP_CLZ32  = 5'd4;
   localparam logic [4:0] OP_CTZ32  = 5'd5;
   localparam logic [4:0] OP_POP32  = 5'd6;
   localparam logic [4:0] OP_EQ     = 5'd7;
   localparam logic [4:0] OP_NE     = 5'd8;
   localparam logic [4:0] OP_LT_S   = 5'd9;
   localparam logic [4:0] OP_LT_U   = 5'd10;
   localparam logic [4:0] OP_GT_S   = 5'd11;
   localparam logic [4:0] OP_GT_U   = 5'd12;
   localparam logic [4:0] OP_LE_S   = 5'd13;
   localparam logic [4:0] OP_LE_U   = 5'd14;
   localparam logic [4:0] OP_GE_S   = 5'd15;
   localparam logic [4:0] OP_GE_U   = 5'd16;
   localparam logic [4:0] OP_ROTL32 = 5'd17;
   localparam logic [4:0] OP_ROTR32 = 5'd18;
   localparam logic [4:0] OP_ROTL64 = 5'd19;
   localparam logic [4:0] OP_ROTR64 = 5'd20;
   localparam logic [4:0] OP_MUL    = 5'd21;
   localparam logic [4:0] OP_DIV_S  = 5'd22;
   localparam logic [4:0] OP_DIV_U  = 5'd23;
   localparam logic [4:0] OP_REM_S  = 5'd24;
   localparam logic [4:0] OP_REM_U  = 5'd25;
   localparam logic [4:0] OP_SHL    = 5'd26;
   localparam logic [4:0] OP_SHR_S  = 5'd27;
   localparam logic [4:0] OP_SHR_U  = 5'd28;

   localparam logic [1:0] FAULT_OK   = 2'd0;
   localparam logic [1:0] FAULT_DIV0 = 2'd1;
   localparam logic [1:0] FAULT_OVF  = 2'd2;

   // Classified item as it sits in the queue
   typedef struct packed {
      logic [4:0]  mode;
      logic [63:0] opa;
      logic [63:0] opb;
      logic [63:0] dvd;
      logic [63:0] dvs;
      logic        neg;
      logic [1:0]  fault;
   } cls_type;

endpackage
`default_nettype wire

[hw/rtl/wia_front.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// wia_front
// Classify an incoming beat: divide faults, operand magnitudes, result sign.
// ---------------------------------------------------------------------------
module wia_front (
   input  wire logic [4:0]       mode,
   input  wire logic [63:0]      opa,
   input  wire logic [63:0]      opb,
   output wia_pkg::cls_type      cls
);
   import wia_pkg::*;

   logic is_div;
   logic is_sgn;
   logic ovf;

   always_comb begin
      is_div = (mode == OP_DIV_S) || (mode == OP_DIV_U) ||
               (mode == OP_REM_S) || (mode == OP_REM_U);
      is_sgn = (mode == OP_DIV_S) || (mode == OP_REM_S);
      ovf    = (opa == {1'b1, 63'd0}) && (opb == {64{1'b1}});
      cls.mode  = mode;
      cls.opa   = opa;
      cls.opb   = opb;
      cls.dvd   = (is_sgn && opa[63]) ? (64'd0 - opa) : opa;
      cls.dvs   = (is_sgn && opb[63]) ? (64'd0 - opb) : opb;
      cls.neg   = (mode == OP_DIV_S) ? (opa[63] ^ opb[63]) :
                  (mode == OP_REM_S) ? opa[63] : 1'b0;
      cls.fault = FAULT_OK;
      if (is_div && opb == 64'd0) begin
         cls.fault = FAULT_DIV0;
      end else if (mode == OP_DIV_S && ovf) begin
         cls.fault = FAULT_OVF;
      end
   end

endmodule
`default_nettype wire

[hw/rtl/wia_queue.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// wia_queue
// Two-entry queue between the classifier and the execution pipeline.
// ---------------------------------------------------------------------------
module wia_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire wia_pkg::cls_type in_data,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output wia_pkg::cls_type      out_data
);
   import wia_pkg::*;

   cls_type    mem_ff [QueueDepth];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   always_comb begin
      in_ready  = (count_ff != 2'(QueueDepth));
      out_valid = (count_ff != 2'd0);
      push      = in_valid && in_ready;
      pop       = out_valid && out_ready;
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
      out_data  = mem_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

   assert property (@(posedge clock) disable iff (reset) count_ff <= 2'(QueueDepth))
      else $error("queue overfilled");
   assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> count_ff == $past(count_ff) - 2'd1)
      else $error("queue count lost a pop");
   assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + 2'd1)
      else $error("queue count lost a push");

endmodule
`default_nettype wire

[hw/rtl/wia_back.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// wia_back
// Execution pipeline: simple ops and partial products in the first stage,
// one restoring divide step per stage after that, final fix-up at the end.
// ---------------------------------------------------------------------------
module wia_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             advance,
   input  wire logic             in_valid,
   input  wire wia_pkg::cls_type in_data,
   output logic                  out_valid,
   output logic [63:0]           out_value,
   output logic [1:0]            out_fault
);
   import wia_pkg::*;

   localparam int unsigned DivSteps = DataWidth;

   typedef struct packed {
      logic        valid;
      logic [4:0]  mode;
      logic [63:0] value;
      logic [1:0]  fault;
      logic        neg;
      logic [63:0] quo;
      logic [63:0] dvs;
      logic [63:0] p_ll;
      logic [31:0] p_lh;
      logic [31:0] p_hl;
   } s0_type;

   typedef struct packed {
      logic        valid;
      logic [4:0]  mode;
      logic [63:0] value;
      logic [1:0]  fault;
      logic        neg;
      logic [63:0] rem;
      logic [63:0] quo;
      logic [63:0] dvs;
   } stg_type;

   function automatic logic [6:0] pop64(input logic [63:0] x);
      logic [6:0] n;
      n = 7'd0;
      for (int i = 0; i < 64; i++) begin
         n = n + {6'd0, x[i]};
      end
      return n;
   endfunction

   function automatic logic [63:0] rev64(input logic [63:0] x);
      logic [63:0] r;
      for (int i = 0; i < 64; i++) begin
         r[i] = x[63 - i];
      end
      return r;
   endfunction

   s0_type      s0_ff, s0_in;
   stg_type     stg_ff [1:DivSteps];
   stg_type     stg_in [1:DivSteps];
   logic        out_valid_ff, out_valid_in;
   logic [63:0] out_value_ff, out_value_in;
   logic [1:0]  out_fault_ff, out_fault_in;

   logic [63:0]  a, b, rv64;
   logic [31:0]  a32, rv32;
   logic [5:0]   s6;
   logic [4:0]   s5;
   logic [127:0] rot64;
   logic [63:0]  rot32;
   logic         lt_s, lt_u;
   logic [63:0]  simple;

   // First stage: simple ops and 32x32 partial products
   always_comb begin
      a     = in_data.opa;
      b     = in_data.opb;
      a32   = a[31:0];
      rv64  = rev64(a);
      rv32  = rv64[63:32];
      s6    = b[5:0];
      s5    = b[4:0];
      lt_s  = $signed(a) < $signed(b);
      lt_u  = a < b;
      rot64 = {a, a} << ((in_data.mode == OP_ROTR64) ? (6'd0 - s6) : s6);
      rot32 = {a32, a32} << ((in_data.mode == OP_ROTR32) ? (5'd0 - s5) : s5);
      simple = 64'd0;
      unique case (in_data.mode)
         OP_EQZ:    simple = {63'd0, a == 64'd0};
         OP_CLZ64:  simple = {57'd0, pop64(~rv64 & (rv64 - 64'd1))};
         OP_CTZ64:  simple = {57'd0, pop64(~a & (a - 64'd1))};
         OP_POP64:  simple = {57'd0, pop64(a)};
         OP_CLZ32:  simple = {57'd0, pop64({32'd0, ~rv32 & (rv32 - 32'd1)})};
         OP_CTZ32:  simple = {57'd0, pop64({32'd0, ~a32 & (a32 - 32'd1)})};
         OP_POP32:  simple = {57'd0, pop64({32'd0, a32})};
         OP_EQ:     simple = {63'd0, a == b};
         OP_NE:     simple = {63'd0, a != b};
         OP_LT_S:   simple = {63'd0, lt_s};
         OP_LT_U:   simple = {63'd0, lt_u};
         OP_GT_S:   simple = {63'd0, $signed(b) < $signed(a)};
         OP_GT_U:   simple = {63'd0, b < a};
         OP_LE_S:   simple = {63'd0, !($signed(b) < $signed(a))};
         OP_LE_U:   simple = {63'd0, !(b < a)};
         OP_GE_S:   simple = {63'd0, !lt_s};
         OP_GE_U:   simple = {63'd0, !lt_u};
         OP_ROTL32,
         OP_ROTR32: simple = {32'd0, rot32[63:32]};
         OP_ROTL64,
         OP_ROTR64: simple = rot64[127:64];
         OP_SHL:    simple = a << s6;
         OP_SHR_S:  simple = 64'($signed(a) >>> s6);
         OP_SHR_U:  simple = a >> s6;
         default:   simple = 64'd0;
      endcase
      s0_in.valid = in_valid;
      s0_in.mode  = in_data.mode;
      s0_in.value = simple;
      s0_in.fault = in_data.fault;
      s0_in.neg   = in_data.neg;
      s0_in.quo   = in_data.dvd;
      s0_in.dvs   = in_data.dvs;
      s0_in.p_ll  = 64'(a[31:0]) * 64'(b[31:0]);
      s0_in.p_lh  = 32'(a[31:0] * b[63:32]);
      s0_in.p_hl  = 32'(a[63:32] * b[31:0]);
   end

   // Divide stages: each shifts one dividend bit in and trial-subtracts
   always_comb begin
      stg_type     prv;
      logic [64:0] sh;
      logic [64:0] df;
      for (int k = 1; k <= int'(DivSteps); k++) begin
         if (k == 1) begin
            prv.valid = s0_ff.valid;
            prv.mode  = s0_ff.mode;
            prv.value = (s0_ff.mode == OP_MUL) ?
                        s0_ff.p_ll + {s0_ff.p_lh + s0_ff.p_hl, 32'd0} : s0_ff.value;
            prv.fault = s0_ff.fault;
            prv.neg   = s0_ff.neg;
            prv.rem   = 64'd0;
            prv.quo   = s0_ff.quo;
            prv.dvs   = s0_ff.dvs;
         end else begin
            prv = stg_ff[k - 1];
         end
         sh = {prv.rem, prv.quo[63]};
         df = sh - {1'b0, prv.dvs};
         stg_in[k] = prv;
         if (!df[64]) begin
            stg_in[k].rem = df[63:0];
            stg_in[k].quo = {prv.quo[62:0], 1'b1};
         end else begin
            stg_in[k].rem = sh[63:0];
            stg_in[k].quo = {prv.quo[62:0], 1'b0};
         end
      end
   end

   // Final select and sign fix-up
   always_comb begin
      stg_type     lst;
      logic [63:0] mag;
      lst = stg_ff[DivSteps];
      mag = ((lst.mode == OP_REM_S) || (lst.mode == OP_REM_U)) ? lst.rem : lst.quo;
      out_valid_in = lst.valid;
      out_fault_in = lst.fault;
      if (lst.fault != FAULT_OK) begin
         out_value_in = 64'd0;
      end else if ((lst.mode == OP_DIV_S) || (lst.mode == OP_DIV_U) ||
                   (lst.mode == OP_REM_S) || (lst.mode == OP_REM_U)) begin
         out_value_in = lst.neg ? (64'd0 - mag) : mag;
      end else begin
         out_value_in = lst.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_ff.valid  <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int k = 1; k <= int'(DivSteps); k++) begin
            stg_ff[k].valid <= 1'b0;
         end
      end else if (advance) begin
         s0_ff        <= s0_in;
         out_valid_ff <= out_valid_in;
         for (int k = 1; k <= int'(DivSteps); k++) begin
            stg_ff[k] <= stg_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_value_ff <= out_value_in;
         out_fault_ff <= out_fault_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_value = out_value_ff;
   assign out_fault = out_fault_ff;

endmodule
`default_nettype wire

[hw/rtl/wasm_integer_alu.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// wasm_integer_alu
// WebAssembly integer helper unit: compares, counts, rotates, mul/div/shift.
// ---------------------------------------------------------------------------
// Usage:
//   Send one beat per operation on the req_ stream: a 5-bit mode and two
//   64-bit operands. Each beat returns exactly one rsp_ beat carrying the
//   64-bit value and a 2-bit fault code, in order.
//   From an accepted request to rsp_tvalid a beat passes through the
//   classifier queue, the first execution stage, 64 divide stages (one
//   restoring step each) and the output register. Every mode travels the
//   same pipeline so results stay in order. Throughput is one beat per
//   cycle unless rsp_ stalls; the pipelined divider sets the depth.
//   The request side stays ready while rsp_ is stalled until the two-entry
//   queue fills; a stall of rsp_tready freezes the whole execution pipeline
//   and holds the output beat.
//   Reset empties the queue and clears every stage valid; no beat is lost
//   or repeated afterwards.
// ---------------------------------------------------------------------------
module wasm_integer_alu (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [135:0] req_tdata,   // mode[4:0], operand_a[68:5], operand_b[132:69]
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [71:0]       rsp_tdata    // value[63:0], fault[65:64]
);
   import wia_pkg::*;

   cls_type     cls;
   cls_type     q_data;
   logic        q_valid;
   logic        advance;
   logic [63:0] value;
   logic [1:0]  fault;

   // Classify the beat on its way into the queue
   wia_front u_front (
      .mode (req_tdata[4:0]),
      .opa  (req_tdata[68:5]),
      .opb  (req_tdata[132:69]),
      .cls  (cls)
   );

   wia_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (cls),
      .out_valid (q_valid),
      .out_ready (advance),
      .out_data  (q_data)
   );

   // Advance the pipeline whenever the output slot is free or being taken
   assign advance = !rsp_tvalid || rsp_tready;

   wia_back u_back (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (q_valid),
      .in_data   (q_data),
      .out_valid (rsp_tvalid),
      .out_value (value),
      .out_fault (fault)
   );

   assign rsp_tdata = {6'd0, fault, value};

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> fault != 2'd3)
      else $error("undefined fault code");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && fault != FAULT_OK) |-> value == 64'd0)
      else $error("faulted beat carries a value");
   assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(value) && $stable(fault))
      else $error("result changed while the pipeline was held");

endmodule
`default_nettype wire

[dv/wasm_integer_alu_test.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wasm_integer_alu_test
// Self-checking bench for the integer helper unit: directed corner beats and
// random operations pass through the req_ stream under random gaps and rsp_
// stalls, and every rsp_ beat is checked in order against a local predictor.
// ---------------------------------------------------------------------------
module wasm_integer_alu_test;
   import wia_pkg::*;

   localparam int unsigned RandomBeats = 1600;
   localparam int unsigned CycleLimit  = 400000;
   localparam int unsigned Latency     = 67;
   localparam logic [63:0] MinSigned   = 64'h8000_0000_0000_0000;
   localparam logic [4:0]  OP_UNUSED   = 5'd29;

   typedef struct packed {
      logic [4:0]  mode;
      logic [63:0] opa;
      logic [63:0] opb;
   } op_beat_t;

   typedef struct packed {
      logic [63:0] value;
      logic [1:0]  fault;
   } alu_result_t;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [135:0] req_tdata;   // mode[4:0], operand_a[68:5], operand_b[132:69]
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [71:0]  rsp_tdata;   // value[63:0], fault[65:64]

   op_beat_t    pending_ops[$];
   alu_result_t expected_results[$];
   int unsigned mismatches;
   int unsigned cycle_count;
   bit          stimulus_done;
   int unsigned send_wait;
   int unsigned recv_wait;
   int unsigned hold_off;      // long receiver stall, counted down in the monitor
   bit          hold_off_used;
   int unsigned accepted_ops;

   wasm_integer_alu u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // ---- predictor ----------------------------------------------------------
   function automatic logic [63:0] lead_zeros(logic [63:0] x, int unsigned width);
      logic [63:0] n;
      n = 0;
      for (int i = width - 1; i >= 0; i--) begin
         if (x[i]) break;
         n++;
      end
      return n;
   endfunction

   function automatic logic [63:0] trail_zeros(logic [63:0] x, int unsigned width);
      logic [63:0] n;
      n = 0;
      for (int i = 0; i < width; i++) begin
         if (x[i]) break;
         n++;
      end
      return n;
   endfunction

   function automatic logic [63:0] ones_count(logic [63:0] x);
      logic [63:0] n;
      n = 0;
      for (int i = 0; i < 64; i++) n += x[i];
      return n;
   endfunction

   function automatic alu_result_t compute_result(op_beat_t op);
      alu_result_t r;
      logic [63:0] a, b, ma, mb, q, rm;
      logic [31:0] a32;
      logic [4:0]  s5;
      logic [5:0]  s6;
      a   = op.opa;
      b   = op.opb;
      a32 = a[31:0];
      s5  = b[4:0];
      s6  = b[5:0];
      r   = '0;
      r.fault = FAULT_OK;
      ma = a[63] ? -a : a;
      mb = b[63] ? -b : b;
      case (op.mode)
         OP_EQZ:    r.value = (a == 0);
         OP_CLZ64:  r.value = lead_zeros(a, 64);
         OP_CTZ64:  r.value = trail_zeros(a, 64);
         OP_POP64:  r.value = ones_count(a);
         OP_CLZ32:  r.value = lead_zeros({32'd0, a32}, 32);
         OP_CTZ32:  r.value = trail_zeros({32'd0, a32}, 32);
         OP_POP32:  r.value = ones_count({32'd0, a32});
         OP_EQ:     r.value = (a == b);
         OP_NE:     r.value = (a != b);
         OP_LT_S:   r.value = ($signed(a) < $signed(b));
         OP_LT_U:   r.value = (a < b);
         OP_GT_S:   r.value = ($signed(a) > $signed(b));
         OP_GT_U:   r.value = (a > b);
         OP_LE_S:   r.value = ($signed(a) <= $signed(b));
         OP_LE_U:   r.value = (a <= b);
         OP_GE_S:   r.value = ($signed(a) >= $signed(b));
         OP_GE_U:   r.value = (a >= b);
         OP_ROTL32: r.value = {32'd0, 32'({a32, a32} >> (6'd32 - s5))};
         OP_ROTR32: r.value = {32'd0, 32'({a32, a32} >> s5)};
         OP_ROTL64: r.value = 64'({a, a} >> (7'd64 - s6));
         OP_ROTR64: r.value = 64'({a, a} >> s6);
         OP_MUL:    r.value = a * b;
         OP_DIV_S, OP_REM_S: begin
            if (b == 0) begin
               r.fault = FAULT_DIV0;
            end else if (a == MinSigned && b == '1) begin
               // overflow faults only on the quotient; remainder is plain zero
               if (op.mode == OP_DIV_S) r.fault = FAULT_OVF;
            end else if (op.mode == OP_DIV_S) begin
               q = ma / mb;
               r.value = (a[63] ^ b[63]) ? -q : q;
            end else begin
               rm = ma % mb;
               r.value = a[63] ? -rm : rm;
            end
         end
         OP_DIV_U:  if (b == 0) r.fault = FAULT_DIV0; else r.value = a / b;
         OP_REM_U:  if (b == 0) r.fault = FAULT_DIV0; else r.value = a % b;
         OP_SHL:    r.value = a << s6;
         OP_SHR_S:  r.value = $signed(a) >>> s6;
         OP_SHR_U:  r.value = a >> s6;
         default:   r = '0;
      endcase
      return r;
   endfunction

   // ---- stimulus -----------------------------------------------------------
   function automatic logic [63:0] rand_word();
      logic [63:0] w;
      w = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0: w = 0;
         1: w = '1;
         2: w = MinSigned;
         3: w = MinSigned - 1;
         4: w = 64'($urandom_range(0, 70));
         5: w = -64'($urandom_range(1, 70));
         6: w = {32'd0, $urandom};
         7: w = w >> $urandom_range(0, 63);
         default: ;
      endcase
      return w;
   endfunction

   task automatic queue_op(logic [4:0] mode, logic [63:0] a, logic [63:0] b);
      op_beat_t op;
      op.mode = mode;
      op.opa  = a;
      op.opb  = b;
      pending_ops.push_back(op);
   endtask

   initial begin
      op_beat_t op;
      // directed: count widths on zero, overflow cases, zero rotates, unused codes
      queue_op(OP_EQZ, 0, 0);
      queue_op(OP_CLZ64, 0, 0);
      queue_op(OP_CTZ64, 0, 0);
      queue_op(OP_POP64, '1, 0);
      queue_op(OP_CLZ32, 64'hFFFF_FFFF_0000_0000, 0);
      queue_op(OP_CTZ32, 64'hFFFF_FFFF_0000_0000, 0);
      queue_op(OP_POP32, '1, 0);
      queue_op(OP_LT_S, MinSigned, MinSigned - 1);
      queue_op(OP_GE_U, MinSigned, MinSigned - 1);
      queue_op(OP_ROTL32, 64'h1234_5678_9ABC_DEF0, 64'h20);
      queue_op(OP_ROTR32, 64'h1234_5678_9ABC_DEF0, 64'd1);
      queue_op(OP_ROTL64, 64'h1234_5678_9ABC_DEF0, 64'h40);
      queue_op(OP_ROTR64, 64'h1234_5678_9ABC_DEF0, 64'd63);
      queue_op(OP_MUL, '1, '1);
      queue_op(OP_DIV_S, MinSigned, '1);
      queue_op(OP_REM_S, MinSigned, '1);
      queue_op(OP_DIV_S, 5, 0);
      queue_op(OP_DIV_U, '1, 0);
      queue_op(OP_REM_S, -64'd7, 2);
      queue_op(OP_REM_U, '1, 0);
      queue_op(OP_SHL, '1, 64'hFFC0);
      queue_op(OP_SHR_S, MinSigned, 63);
      queue_op(OP_SHR_U, '1, '1);
      queue_op(OP_UNUSED, '1, '1);
      queue_op(5'd31, '1, '1);
      for (int i = 0; i < RandomBeats; i++) begin
         op.mode = ($urandom_range(0, 40) == 0) ? 5'($urandom_range(29, 31))
                                                : 5'($urandom_range(0, 28));
         op.opa  = rand_word();
         op.opb  = ($urandom_range(0, 3) == 0) ? op.opa : rand_word();
         pending_ops.push_back(op);
      end
   end

   // ---- driver: hold each beat until accepted, then draw a fresh gap --------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         send_wait  <= 0;
      end else if (req_tvalid && !req_tready) begin
         // hold the offered beat
      end else if (send_wait != 0) begin
         req_tvalid <= 1'b0;
         send_wait  <= send_wait - 1;
      end else if (pending_ops.size() != 0) begin
         op_beat_t op;
         op = pending_ops.pop_front();
         expected_results.push_back(compute_result(op));
         req_tvalid <= 1'b1;
         req_tdata  <= {3'd0, op.opb, op.opa, op.mode};
         // stretches without gaps every so often
         send_wait  <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
      end else begin
         req_tvalid <= 1'b0;
         stimulus_done <= 1'b1;
      end
   end

   // ---- monitor: stall rsp_ at random, check each accepted beat -------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_wait  <= 0;
         hold_off   <= 0;
      end else begin
         if (req_tvalid && req_tready) accepted_ops <= accepted_ops + 1;
         if (rsp_tvalid && rsp_tready) begin
            alu_result_t got, want;
            got = {rsp_tdata[63:0], rsp_tdata[65:64]};
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result beat value=%h fault=%0d",
                        $time, got.value, got.fault);
               mismatches++;
            end else begin
               want = expected_results.pop_front();
               if (got.value !== want.value) begin
                  $display("%0t: value expected %h actual %h", $time, want.value,
                           got.value);
                  mismatches++;
               end
               if (got.fault !== want.fault) begin
                  $display("%0t: fault expected %0d actual %0d", $time, want.fault,
                           got.fault);
                  mismatches++;
               end
            end
         end
         // once, after a while, hold off long enough to back up the input
         if (!hold_off_used && accepted_ops == 300) begin
            hold_off_used <= 1'b1;
            hold_off      <= 200;
            rsp_tready    <= 1'b0;
         end else if (hold_off != 0) begin
            hold_off   <= hold_off - 1;
            rsp_tready <= (hold_off == 1);
         end else if (recv_wait != 0) begin
            recv_wait  <= recv_wait - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (rsp_tvalid && rsp_tready)
               recv_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
         end
      end
   end

   // ---- reset, timeout and end of run -------------------------------------
   initial begin
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      rsp_tready    = 1'b0;
      mismatches    = 0;
      cycle_count   = 0;
      stimulus_done = 1'b0;
      hold_off_used = 1'b0;
      accepted_ops  = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      while (!(stimulus_done && expected_results.size() == 0) &&
             cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      if (cycle_count >= CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("** wasm_integer_alu: FAILED **");
      end else begin
         // drain: catch any stray beat the block might still emit
         repeat (Latency + 10) @(posedge clock);
         if (mismatches == 0 && expected_results.size() == 0)
            $display("** wasm_integer_alu: PASSED **");
         else
            $display("** wasm_integer_alu: FAILED **");
      end
      $finish;
   end

endmodule

[files.f]
hw/rtl/wia_pkg.sv
hw/rtl/wia_front.sv
hw/rtl/wia_queue.sv
hw/rtl/wia_back.sv
hw/rtl/wasm_integer_alu.sv
dv/wasm_integer_alu_test.sv
